[hw/rtl/sprite_frame_sequencer_top_macros.svh]
// Assertion helpers shared by the checking code of the frame sequencer.
`ifndef SPRITE_FRAME_SEQUENCER_TOP_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame sequencer check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame sequencer check failed (next cycle)");

`endif

[hw/rtl/sfs_pkg.sv]
`timescale 1ns / 1ps
package sfs_pkg;

   // Command codes carried in req_tuser.
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_PLAY = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;

   // Clip playback modes; the unused code behaves as loop.
   localparam logic [1:0] MODE_LOOP     = 2'd0;
   localparam logic [1:0] MODE_ONCE     = 2'd1;
   localparam logic [1:0] MODE_PINGPONG = 2'd2;

   // Register indexes on the csr port.
   localparam logic CSR_SPEED  = 1'b0;
   localparam logic CSR_ATTACH = 1'b1;

   // Widths.
   localparam int POS_W      = 9;
   localparam int PERIOD_W   = 32;
   localparam int DIVISOR_W  = 31;
   localparam int DIVIDEND_W = 37;
   localparam int DIV_CNT_W  = 6;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   // Outcome of one frame step.
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             back;
      logic             halt;
      logic             clr_acc;
   } step_type;

endpackage

[hw/rtl/sfs_divider.sv]
`timescale 1ns / 1ps
module sfs_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sfs_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [sfs_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             done,
   output logic [sfs_pkg::PERIOD_W-1:0]     quotient
);
   import sfs_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W+1:0]  diff;
   logic                  fits;

   // One restoring step per cycle: shift in a dividend bit, try the subtract.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};
   assign fits  = ~diff[DIVISOR_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   // A quotient beyond 32 bits saturates.
   assign done     = done_ff;
   assign quotient = (|quo_ff[DIVIDEND_W-1:PERIOD_W]) ? '1 : quo_ff[PERIOD_W-1:0];

endmodule

[hw/rtl/sfs_frame_step.sv]
`timescale 1ns / 1ps
module sfs_frame_step (
   input  logic [sfs_pkg::POS_W-1:0] pos,
   input  logic [sfs_pkg::POS_W-1:0] frames,
   input  logic [1:0]                mode,
   input  logic                      back,
   output sfs_pkg::step_type         step
);
   import sfs_pkg::*;

   logic [POS_W:0]   pos_inc;
   logic [POS_W-1:0] pos_dec;
   logic             at_end;
   logic             at_start;

   assign pos_inc  = {1'b0, pos} + 1'b1;
   assign pos_dec  = pos - 1'b1;
   assign at_end   = pos_inc >= {1'b0, frames};
   assign at_start = (pos == '0);

   // Move one frame, then wrap, clamp or bounce at the clip ends.
   always_comb begin
      step.pos     = back ? pos_dec : pos_inc[POS_W-1:0];
      step.back    = back;
      step.halt    = 1'b0;
      step.clr_acc = 1'b0;
      case (mode)
         MODE_ONCE: begin
            if (!back && at_end) begin
               step.pos     = frames - 1'b1;
               step.halt    = 1'b1;
               step.clr_acc = 1'b1;
            end else if (back && at_start) begin
               step.pos     = '0;
               step.halt    = 1'b1;
               step.clr_acc = 1'b1;
            end
         end
         MODE_PINGPONG: begin
            if (frames <= POS_W'(1)) begin
               step.pos  = '0;
               step.halt = 1'b1;
            end else if (!back && at_end) begin
               step.pos  = frames - POS_W'(2);
               step.back = 1'b1;
            end else if (back && at_start) begin
               step.pos  = POS_W'(1);
               step.back = 1'b0;
            end
         end
         default: begin
            if (!back && at_end) begin
               step.pos = '0;
            end else if (back && at_start) begin
               step.pos = frames - 1'b1;
            end
         end
      endcase
   end

endmodule

[hw/rtl/sprite_frame_sequencer_top.sv]
`timescale 1ns / 1ps
// Play, stop, unused commands and ignored ticks go from acceptance straight to S_OUT.
// A stepping tick runs S_MUL (the divider takes the product), S_DIV (radix-2 divider),
// S_ACC (accumulate), S_STEP (n frames stepped, at most MAX_STEPS_PER_TICK) and S_OUT.
// S_OUT registers the result word once the previous one has been taken.
// Throughput: one word at a time; the next word is accepted once the result is registered.
// Reset (synchronous, active high): no clip active, speed 1.0, no target attached.
module sprite_frame_sequencer_top #(
   parameter int MAX_FRAMES         = 256,
   parameter int MAX_STEPS_PER_TICK = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // From bit 0: elapsed_time[23:0], clip_id[31:24], restart[32], clip_frames[41:33],
   // clip_rate[57:42], clip_mode[59:58], zero fill[63:60].
   input  logic [sfs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // From bit 0: command[1:0].
   input  logic [1:0]                       req_tuser,
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // From bit 0: frame_index[7:0], clip_active[8], active_clip[16:9],
   // moving_backward[17], steps_capped[18], zero fill[23:19].
   output logic [sfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration port.
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [15:0]                      csr_wdata
);
   import sfs_pkg::*;

   localparam int STEP_W = $clog2(MAX_STEPS_PER_TICK + 1);
   localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_STEPS_PER_TICK);
   localparam logic [POS_W-1:0] FRAMES_CAP =
      (MAX_FRAMES > 511) ? 9'd511 : POS_W'(MAX_FRAMES);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_DIV  = 6'b000100,
      S_ACC  = 6'b001000,
      S_STEP = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [15:0]           speed_ff, speed_in;
   logic                  attached_ff, attached_in;
   logic                  active_ff, active_in;
   logic [7:0]            clip_ff, clip_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  dir_ff, dir_in;
   logic [PERIOD_W-1:0]   acc_ff, acc_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [POS_W-1:0]      frames_ff, frames_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  rate_zero_ff, rate_zero_in;
   logic [15:0]           rate_ff, rate_in;
   logic [23:0]           elapsed_ff, elapsed_in;
   logic                  run_back_ff, run_back_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   logic                  capped_ff, capped_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request fields.
   logic [23:0]      f_elapsed;
   logic [7:0]       f_clip_id;
   logic             f_restart;
   logic [POS_W-1:0] f_frames;
   logic [15:0]      f_rate;
   logic [1:0]       f_mode;
   logic [POS_W-1:0] frames_sat;

   logic [15:0]           speed_mag;
   logic [PERIOD_W-1:0]   prod;
   logic                  div_start;
   logic                  div_done;
   logic [PERIOD_W-1:0]   div_quot;
   logic                  tick_ignored;
   logic [PERIOD_W:0]     acc_sum;
   logic [PERIOD_W:0]     acc_diff;
   logic                  period_fits;
   step_type              step;

   assign f_elapsed = req_tdata[23:0];
   assign f_clip_id = req_tdata[31:24];
   assign f_restart = req_tdata[32];
   assign f_frames  = req_tdata[41:33];
   assign f_rate    = req_tdata[57:42];
   assign f_mode    = req_tdata[59:58];
   assign frames_sat = (f_frames > FRAMES_CAP) ? FRAMES_CAP : f_frames;

   // Period = round(2^36 / (rate * |speed|)); the product is registered by the divider.
   assign speed_mag = speed_ff[15] ? (~speed_ff + 16'd1) : speed_ff;
   assign prod      = rate_ff * speed_mag;
   assign div_start = (state_ff == S_MUL);

   sfs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({1'b1, 5'b00000, prod[PERIOD_W-1:1]}),
      .divisor  (prod[DIVISOR_W-1:0]),
      .done     (div_done),
      .quotient (div_quot)
   );

   sfs_frame_step u_step (
      .pos    (pos_ff),
      .frames (frames_ff),
      .mode   (mode_ff),
      .back   (run_back_ff),
      .step   (step)
   );

   assign tick_ignored = !attached_ff || !active_ff || (frames_ff == '0) ||
                         rate_zero_ff || (speed_ff == '0);

   // Shared compare and subtract of the accumulator against the period.
   assign acc_sum     = {1'b0, acc_ff} + {9'd0, elapsed_ff};
   assign acc_diff    = {1'b0, acc_ff} - {1'b0, period_ff};
   assign period_fits = ~acc_diff[PERIOD_W];

   assign req_tready = (state_ff == S_IDLE);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      speed_in     = speed_ff;
      attached_in  = attached_ff;
      active_in    = active_ff;
      clip_in      = clip_ff;
      pos_in       = pos_ff;
      dir_in       = dir_ff;
      acc_in       = acc_ff;
      period_in    = period_ff;
      frames_in    = frames_ff;
      mode_in      = mode_ff;
      rate_zero_in = rate_zero_ff;
      rate_in      = rate_ff;
      elapsed_in   = elapsed_ff;
      run_back_in  = run_back_ff;
      steps_in     = steps_ff;
      capped_in    = capped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // The user must write registers only while idle; the block itself does not enforce it.
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SPEED:  speed_in    = csr_wdata;
            CSR_ATTACH: attached_in = csr_wdata[0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               capped_in  = 1'b0;
               elapsed_in = f_elapsed;
               state_in   = S_OUT;
               case (req_tuser)
                  CMD_TICK: begin
                     if (!tick_ignored) begin
                        state_in = S_MUL;
                     end
                  end
                  CMD_PLAY: begin
                     if (!(active_ff && (f_clip_id == clip_ff) && !f_restart)) begin
                        active_in    = 1'b1;
                        clip_in      = f_clip_id;
                        frames_in    = frames_sat;
                        rate_in      = f_rate;
                        rate_zero_in = (f_rate == '0);
                        mode_in      = f_mode;
                        acc_in       = '0;
                        dir_in       = speed_ff[15];
                        pos_in       = (speed_ff[15] && (frames_sat != '0)) ?
                                       frames_sat - 1'b1 : '0;
                     end
                  end
                  CMD_STOP: begin
                     active_in = 1'b0;
                     clip_in   = '0;
                     pos_in    = '0;
                     acc_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               period_in = div_quot;
               state_in  = S_ACC;
            end
         end
         S_ACC: begin
            acc_in      = acc_sum[PERIOD_W] ? '1 : acc_sum[PERIOD_W-1:0];
            run_back_in = speed_ff[15] | dir_ff;
            steps_in    = '0;
            state_in    = S_STEP;
         end
         S_STEP: begin
            if (!period_fits) begin
               dir_in   = run_back_ff;
               state_in = S_OUT;
            end else if (steps_ff == STEP_LIMIT) begin
               capped_in = 1'b1;
               dir_in    = run_back_ff;
               state_in  = S_OUT;
            end else begin
               steps_in    = steps_ff + 1'b1;
               acc_in      = step.clr_acc ? '0 : acc_diff[PERIOD_W-1:0];
               pos_in      = step.pos;
               run_back_in = step.back;
               // A halting step leaves the stored direction as it was.
               if (step.halt) begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b00000, capped_ff, dir_ff,
                               active_ff ? clip_ff : 8'd0, active_ff, pos_ff[7:0]};
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         speed_ff     <= 16'h1000;
         attached_ff  <= 1'b0;
         active_ff    <= 1'b0;
         clip_ff      <= '0;
         pos_ff       <= '0;
         dir_ff       <= 1'b0;
         acc_ff       <= '0;
         period_ff    <= '0;
         frames_ff    <= '0;
         mode_ff      <= MODE_LOOP;
         rate_zero_ff <= 1'b1;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         attached_ff  <= attached_in;
         active_ff    <= active_in;
         clip_ff      <= clip_in;
         pos_ff       <= pos_in;
         dir_ff       <= dir_in;
         acc_ff       <= acc_in;
         period_ff    <= period_in;
         frames_ff    <= frames_in;
         mode_ff      <= mode_in;
         rate_zero_ff <= rate_zero_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      elapsed_ff  <= elapsed_in;
      run_back_ff <= run_back_in;
      steps_ff    <= steps_in;
      capped_ff   <= capped_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/sfs_checker.sv]
`timescale 1ns / 1ps
`include "sprite_frame_sequencer_top_macros.svh"
module sfs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sfs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sfs_pkg::*;

   // A stalled result word holds its contents.
   `SFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // With no clip selected the reported clip id reads as zero.
   `SFS_ASSERT_NOW(a_idle_clip, clock, reset, rsp_tvalid && !rsp_tdata[8], rsp_tdata[16:9] == 8'd0)

   // The step limit can only be hit while a clip is playing.
   `SFS_ASSERT_NOW(a_cap_active, clock, reset, rsp_tvalid && rsp_tdata[18], rsp_tdata[8])

   // The block works on one word at a time.
   `SFS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind sprite_frame_sequencer_top sfs_checker u_sfs_checker (.*);

[tb/sv/tb_sprite_frame_sequencer_top.sv]
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer_top;
   import sfs_pkg::*;

   localparam int MAX_FRAMES         = 256;
   localparam int MAX_STEPS_PER_TICK = 64;
   // Cycles without any accepted word before the run is declared hung.
   localparam int STALL_LIMIT        = 2000;
   // Long enough to drain a full stepping tick.
   localparam int DRAIN_CYCLES       = 150;
   // Random commands sent in each phase of the random traffic.
   localparam int WORDS_PER_PHASE    = 14;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Request fields in req_tdata order, elapsed_time in the lowest bits.
   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] rate;
      logic [8:0]  frames;
      logic        restart;
      logic [7:0]  clip_id;
      logic [23:0] elapsed;
   } clip_request_type;

   // Result fields in rsp_tdata order, frame_index in the lowest bits.
   typedef struct packed {
      logic       steps_capped;
      logic       moving_backward;
      logic [7:0] active_clip;
      logic       clip_active;
      logic [7:0] frame_index;
   } frame_report_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_addr;
   logic [15:0]           csr_wdata;

   // Sequencer state as the testbench expects it.
   logic signed [15:0] model_speed    = 16'sd4096;
   logic               model_attached = 1'b0;
   logic               seq_active     = 1'b0;
   logic [7:0]         seq_clip       = 8'd0;
   int                 seq_pos        = 0;
   logic               seq_backward   = 1'b0;
   logic [31:0]        seq_acc        = 32'd0;
   int                 seq_frames     = 0;
   logic [1:0]         seq_mode       = MODE_LOOP;
   logic [15:0]        seq_rate       = 16'd0;

   frame_report_type pending_reports[$];
   int               failures     = 0;
   int               quiet_cycles = 0;
   logic             no_gaps      = 1'b0;

   sprite_frame_sequencer_top #(
      .MAX_FRAMES        (MAX_FRAMES),
      .MAX_STEPS_PER_TICK(MAX_STEPS_PER_TICK)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Frame period in Q16.16 seconds: 2^36 / (rate * |speed|), rounded half up, saturated.
   function automatic logic [31:0] period_for(logic [15:0] rate, int mag);
      logic [63:0] prod;
      logic [63:0] quot;
      prod = 64'(rate) * 64'(mag);
      quot = ((64'd1 << 36) + (prod >> 1)) / prod;
      return (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
   endfunction

   // Advances the expected state by one tick and tells whether the step limit was hit.
   function automatic logic tick_sequencer(logic [23:0] elapsed);
      int          speed;
      int          dirv;
      int          steps;
      logic [31:0] period;
      logic [32:0] sum;
      logic        capped;
      speed  = int'(model_speed);
      steps  = 0;
      capped = 1'b0;
      if (!model_attached || !seq_active || seq_frames == 0 || seq_rate == 16'd0 ||
          speed == 0)
         return 1'b0;
      period  = period_for(seq_rate, (speed < 0) ? -speed : speed);
      sum     = {1'b0, seq_acc} + {9'd0, elapsed};
      seq_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      dirv    = (speed < 0 || seq_backward) ? -1 : 1;
      while (seq_acc >= period) begin
         if (steps >= MAX_STEPS_PER_TICK) begin
            capped = 1'b1;
            break;
         end
         steps++;
         seq_acc -= period;
         seq_pos += dirv;
         case (seq_mode)
            MODE_ONCE: begin
               // Clamp at either end and stop for good.
               if ((dirv > 0 && seq_pos >= seq_frames) || (dirv < 0 && seq_pos < 0)) begin
                  seq_pos = (dirv > 0) ? seq_frames - 1 : 0;
                  seq_acc = 32'd0;
                  dirv    = 0;
               end
            end
            MODE_PINGPONG: begin
               if (seq_frames <= 1) begin
                  seq_pos = 0;
                  dirv    = 0;
               end else if (dirv > 0 && seq_pos >= seq_frames) begin
                  seq_pos = seq_frames - 2;
                  dirv    = -1;
               end else if (dirv < 0 && seq_pos < 0) begin
                  seq_pos = 1;
                  dirv    = 1;
               end
            end
            default: begin
               // Loop, and the unused mode code behaves the same.
               if (dirv > 0 && seq_pos >= seq_frames)
                  seq_pos = 0;
               else if (dirv < 0 && seq_pos < 0)
                  seq_pos = seq_frames - 1;
            end
         endcase
         if (dirv == 0)
            break;
      end
      if (dirv != 0)
         seq_backward = (dirv < 0);
      return capped;
   endfunction

   // Applies one accepted command word to the expected state and builds its result.
   function automatic frame_report_type apply_command(logic [1:0] cmd, clip_request_type r);
      frame_report_type rpt;
      rpt.steps_capped = 1'b0;
      case (cmd)
         CMD_TICK: rpt.steps_capped = tick_sequencer(r.elapsed);
         CMD_PLAY: begin
            if (!(seq_active && r.clip_id == seq_clip && !r.restart)) begin
               seq_active   = 1'b1;
               seq_clip     = r.clip_id;
               seq_frames   = (r.frames > MAX_FRAMES) ? MAX_FRAMES : int'(r.frames);
               seq_rate     = r.rate;
               seq_mode     = r.mode;
               seq_acc      = 32'd0;
               seq_backward = (model_speed < 0);
               seq_pos      = (seq_backward && seq_frames > 0) ? seq_frames - 1 : 0;
            end
         end
         CMD_STOP: begin
            seq_active = 1'b0;
            seq_clip   = 8'd0;
            seq_pos    = 0;
            seq_acc    = 32'd0;
         end
         default: ;
      endcase
      rpt.frame_index     = seq_pos[7:0];
      rpt.clip_active     = seq_active;
      rpt.active_clip     = seq_active ? seq_clip : 8'd0;
      rpt.moving_backward = seq_backward;
      return rpt;
   endfunction

   function automatic clip_request_type noise_request();
      logic [59:0] bits;
      bits = 60'({$urandom, $urandom});
      return bits;
   endfunction

   // Sends one command word after a random gap and records its expected result.
   task automatic send_word(input logic [1:0] cmd, input clip_request_type r);
      int               gap;
      frame_report_type rpt;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {4'd0, r};
      req_tuser  <= cmd;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rpt             = apply_command(cmd, r);
      pending_reports = {pending_reports, rpt};
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [23:0] elapsed);
      clip_request_type r;
      r         = noise_request();
      r.elapsed = elapsed;
      send_word(CMD_TICK, r);
   endtask

   task automatic send_play(input logic [7:0] id, input logic restart,
                            input logic [8:0] frames, input logic [15:0] rate,
                            input logic [1:0] mode);
      clip_request_type r;
      r         = noise_request();
      r.clip_id = id;
      r.restart = restart;
      r.frames  = frames;
      r.rate    = rate;
      r.mode    = mode;
      send_word(CMD_PLAY, r);
   endtask

   task automatic send_other(input logic [1:0] cmd);
      send_word(cmd, noise_request());
   endtask

   // Drops valid and waits until every expected result word has been taken.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   // Writes both registers once the block has gone idle.
   task automatic reconfigure(input logic signed [15:0] speed, input logic attach);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SPEED;
      csr_wdata <= speed;
      @(negedge clock);
      csr_addr  <= CSR_ATTACH;
      csr_wdata <= {15'd0, attach};
      @(negedge clock);
      csr_we    <= 1'b0;
      model_speed    = speed;
      model_attached = attach;
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_report(input frame_report_type got);
      frame_report_type want;
      if (pending_reports.size() == 0) begin
         $display("%0t ns: result word %h with no command waiting, expected none, actual %h",
                  $time, got, got);
         failures++;
      end else begin
         want = pending_reports.pop_front();
         compare_field("frame_index", want.frame_index, got.frame_index);
         compare_field("clip_active", want.clip_active, got.clip_active);
         compare_field("active_clip", want.active_clip, got.active_clip);
         compare_field("moving_backward", want.moving_backward, got.moving_backward);
         compare_field("steps_capped", want.steps_capped, got.steps_capped);
      end
   endtask

   // Result side: random stall before each word, then check it when taken.
   initial begin : result_monitor
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_report(rsp_tdata[18:0]);
         @(negedge clock);
      end
   end

   // Ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Without a target every tick is ignored; an unused command just reports state, stop clears the clip.
   task automatic test_ignored_ticks();
      send_tick(24'hFF_FFFF);
      send_play(8'd7, 1'b1, 9'd4, 16'h0C00, MODE_LOOP);
      send_tick(24'hFF_FFFF);
      send_other(CMD_UNUSED);
      send_other(CMD_STOP);
   endtask

   // Forward loop at 12 frames per second: one frame is 5461 time units.
   task automatic test_loop_playback();
      reconfigure(16'sd4096, 1'b1);
      send_play(8'd0, 1'b0, 9'd4, 16'h0C00, MODE_LOOP);
      send_tick(24'd0);
      send_tick(24'd27305);
      send_play(8'd0, 1'b0, 9'd2, 16'h0100, MODE_ONCE);
      send_play(8'd1, 1'b1, 9'd3, 16'h0C00, MODE_UNUSED);
      send_tick(24'h00_C000);
   endtask

   // Once clamps at the end; ping-pong bounces; one frame, no frames and zero rate stall.
   task automatic test_once_and_pingpong();
      send_play(8'd2, 1'b1, 9'd3, 16'h0C00, MODE_ONCE);
      send_tick(24'hFF_FFFF);
      send_play(8'd3, 1'b1, 9'd4, 16'h0C00, MODE_PINGPONG);
      send_tick(24'd38227);
      send_play(8'd4, 1'b1, 9'd1, 16'h1E00, MODE_PINGPONG);
      send_tick(24'h00_4000);
      send_play(8'd5, 1'b1, 9'd0, 16'h0C00, MODE_LOOP);
      send_tick(24'h00_4000);
      send_play(8'd6, 1'b1, 9'd5, 16'h0000, MODE_LOOP);
      send_tick(24'h00_4000);
   endtask

   // Negative speed starts at the last frame; frame counts above the limit saturate.
   task automatic test_reverse_and_freeze();
      reconfigure(-16'sd4096, 1'b1);
      send_play(8'd255, 1'b1, 9'h1FF, 16'h0C00, MODE_LOOP);
      send_tick(24'd20000);
      reconfigure(16'sd0, 1'b1);
      send_tick(24'hFF_FFFF);
      send_play(8'd255, 1'b0, 9'd3, 16'h0C00, MODE_ONCE);
      send_play(8'd255, 1'b1, 9'd3, 16'h0C00, MODE_ONCE);
   endtask

   // Fastest clip at extreme speeds hits the per-tick step limit and keeps the leftover.
   task automatic test_step_limit();
      reconfigure(16'sd32767, 1'b1);
      send_play(8'd255, 1'b1, 9'd256, 16'hFFFF, MODE_LOOP);
      send_tick(24'hFF_FFFF);
      send_tick(24'd0);
      reconfigure(-16'sd32768, 1'b1);
      send_tick(24'hFF_FFFF);
      send_other(CMD_STOP);
   endtask

   // Slowest clip: the period saturates and the accumulator must saturate to reach it.
   task automatic test_accumulator_saturation();
      reconfigure(16'sd1, 1'b1);
      send_play(8'd9, 1'b1, 9'd2, 16'h0001, MODE_LOOP);
      repeat (257) send_tick(24'hFF_FFFF);
   endtask

   // Phases of random commands, each under its own speed and target setting.
   task automatic test_random_traffic();
      logic signed [15:0] speed;
      logic [15:0]        rate;
      logic [8:0]         frames;
      logic [7:0]         id;
      int                 pick;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       speed = 16'sd4096;
            1:       speed = -16'sd4096;
            2:       speed = 16'sd32767;
            3:       speed = -16'sd32768;
            4:       speed = 16'sd0;
            5:       speed = 16'sd2048;
            default: speed = 16'($urandom);
         endcase
         reconfigure(speed, phase != 6);
         no_gaps = (phase == 3 || phase == 5);
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_tick(24'($urandom) >> $urandom_range(0, 24));
            end else if (pick < 88) begin
               // Mostly a few clip ids so that replays of the current clip occur.
               id     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
               frames = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 12));
               case ($urandom_range(0, 9))
                  0:       rate = 16'd0;
                  1, 2:    rate = 16'($urandom);
                  default: rate = 16'($urandom_range(16'h0100, 16'h3C00));
               endcase
               send_play(id, 1'($urandom), frames, rate, 2'($urandom));
            end else if (pick < 96) begin
               send_other(CMD_STOP);
            end else begin
               send_other(CMD_UNUSED);
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_TICK;
      csr_we     = 1'b0;
      csr_addr   = CSR_SPEED;
      csr_wdata  = 16'd0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_ignored_ticks();
      test_loop_playback();
      test_once_and_pingpong();
      test_reverse_and_freeze();
      test_step_limit();
      test_accumulator_saturation();
      test_random_traffic();

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_divider.sv
hw/rtl/sfs_frame_step.sv
hw/rtl/sprite_frame_sequencer_top.sv
hw/rtl/sfs_checker.sv
tb/sv/tb_sprite_frame_sequencer_top.sv
